// ===== src/gtb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gtb_pkg;

    localparam int unsigned MAX_VERTICES = 16;
    localparam int unsigned VTX_W = 4;
    localparam int unsigned CNT_W = 5;
    localparam int unsigned DEG_W = 2;

    localparam logic             OP_CLEAR  = 1'b0;
    localparam logic             OP_EDGE   = 1'b1;
    localparam logic [DEG_W-1:0] DEG_FULL  = 2'd2;
    localparam logic [CNT_W-1:0] COUNT_MIN = 5'd2;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd16;
    localparam logic [CNT_W-1:0] COUNT_RST = 5'd16;

    typedef enum logic [2:0] {
        ST_PATH    = 3'd0,
        ST_CLOSE   = 3'd1,
        ST_DEGREE  = 3'd2,
        ST_ROOT    = 3'd3,
        ST_DONE    = 3'd4,
        ST_CLEARED = 3'd5
    } gtb_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_A,
        S_CHK_B,
        S_WALK_A,
        S_WALK_B,
        S_DECIDE,
        S_INC_B,
        S_RESP
    } gtb_state_t;

    typedef struct packed {
        logic             clear;
        logic [VTX_W-1:0] link_addr;
        logic             link_we;
        logic [VTX_W-1:0] link_waddr;
        logic [VTX_W-1:0] link_wdata;
        logic [VTX_W-1:0] deg_addr;
        logic             deg_inc;
    } gtb_store_ctrl_t;

    typedef struct packed {
        logic [VTX_W-1:0] link_rdata;
        logic [DEG_W-1:0] deg_rdata;
    } gtb_store_rd_t;

endpackage

`default_nettype wire

// ===== src/gtb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gtb_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [3:0] from_vertex;
    logic [3:0] to_vertex;

    modport source (output valid, output operation, output from_vertex, output to_vertex,
                    input ready);
    modport sink (input valid, input operation, input from_vertex, input to_vertex,
                  output ready);
endinterface

`default_nettype wire

// ===== src/gtb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gtb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] tour_slot;
    logic       tour_complete;

    modport source (output valid, output status, output tour_slot, output tour_complete,
                    input ready);
    modport sink (input valid, input status, input tour_slot, input tour_complete,
                  output ready);
endinterface

`default_nettype wire

// ===== src/gtb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtb_store (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire gtb_pkg::gtb_store_ctrl_t ctrl,
    output gtb_pkg::gtb_store_rd_t        rd
);
    import gtb_pkg::*;

    logic [VTX_W-1:0] link_reg [MAX_VERTICES];
    logic [DEG_W-1:0] deg_reg  [MAX_VERTICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                link_reg[i] <= VTX_W'(i);
                deg_reg[i]  <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                link_reg[i] <= VTX_W'(i);
                deg_reg[i]  <= '0;
            end
        end
        else
        begin
            if (ctrl.link_we)
            begin
                link_reg[ctrl.link_waddr] <= ctrl.link_wdata;
            end
            if (ctrl.deg_inc)
            begin
                deg_reg[ctrl.deg_addr] <= deg_reg[ctrl.deg_addr] + DEG_W'(1);
            end
        end
    end

    assign rd.link_rdata = link_reg[ctrl.link_addr];
    assign rd.deg_rdata  = deg_reg[ctrl.deg_addr];

endmodule

`default_nettype wire

// ===== src/gtb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtb_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [gtb_pkg::CNT_W-1:0]   live_count,
    gtb_in_if.sink                           in_ch,
    gtb_out_if.source                        out_ch
);
    import gtb_pkg::*;

    gtb_state_t       state_reg, state_next;
    logic [VTX_W-1:0] a_reg, a_next;
    logic [VTX_W-1:0] b_reg, b_next;
    logic [VTX_W-1:0] cur_reg, cur_next;
    logic [VTX_W-1:0] ra_reg, ra_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    gtb_status_t      status_reg, status_next;
    logic [VTX_W-1:0] slot_reg, slot_next;
    logic             out_valid_reg, out_valid_next;
    gtb_status_t      out_status_reg, out_status_next;
    logic [VTX_W-1:0] out_slot_reg, out_slot_next;
    logic             out_complete_reg, out_complete_next;

    gtb_store_ctrl_t  sctl;
    gtb_store_rd_t    srd;

    logic             in_fire;
    logic             out_free;
    logic             out_of_range;
    logic             deg_full;
    logic             at_root;
    logic             path_phase;
    logic             roots_same;
    logic             edge_taken;
    logic [CNT_W-1:0] last_slot;

    gtb_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sctl),
        .rd    (srd)
    );

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign in_fire              = in_ch.valid && in_ch.ready;
    assign out_free             = !out_valid_reg || out_ch.ready;
    assign out_of_range         = ({1'b0, in_ch.from_vertex} >= live_count)
                               || ({1'b0, in_ch.to_vertex} >= live_count);
    assign deg_full             = (srd.deg_rdata == DEG_FULL);
    assign at_root              = (srd.link_rdata == cur_reg);
    assign last_slot            = live_count - CNT_W'(1);
    assign path_phase           = (count_reg < last_slot);
    assign roots_same           = (ra_reg == cur_reg);
    assign edge_taken           = path_phase ? !roots_same : roots_same;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.tour_slot     = out_slot_reg;
    assign out_ch.tour_complete = out_complete_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.operation == OP_CLEAR || closed_reg || out_of_range)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_CHK_A;
                    end
                end
            end
            S_CHK_A:  state_next = deg_full ? S_RESP : S_CHK_B;
            S_CHK_B:  state_next = (deg_full || a_reg == b_reg) ? S_RESP : S_WALK_A;
            S_WALK_A: state_next = at_root ? S_WALK_B : S_WALK_A;
            S_WALK_B: state_next = at_root ? S_DECIDE : S_WALK_B;
            S_DECIDE: state_next = edge_taken ? S_INC_B : S_RESP;
            S_INC_B:  state_next = S_RESP;
            S_RESP:   state_next = out_free ? S_IDLE : S_RESP;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        a_next            = a_reg;
        b_next            = b_reg;
        cur_next          = cur_reg;
        ra_next           = ra_reg;
        count_next        = count_reg;
        closed_next       = closed_reg;
        status_next       = status_reg;
        slot_next         = slot_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_status_next   = out_status_reg;
        out_slot_next     = out_slot_reg;
        out_complete_next = out_complete_reg;
        sctl              = '0;
        sctl.link_addr    = cur_reg;
        sctl.link_waddr   = cur_reg;
        sctl.link_wdata   = ra_reg;
        sctl.deg_addr     = a_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    a_next    = in_ch.from_vertex;
                    b_next    = in_ch.to_vertex;
                    cur_next  = in_ch.from_vertex;
                    slot_next = '0;
                    if (in_ch.operation == OP_CLEAR)
                    begin
                        sctl.clear  = 1'b1;
                        count_next  = '0;
                        closed_next = 1'b0;
                        status_next = ST_CLEARED;
                    end
                    else if (closed_reg)
                    begin
                        status_next = ST_DONE;
                    end
                    else if (out_of_range)
                    begin
                        status_next = ST_DEGREE;
                    end
                end
            end
            S_CHK_A:
            begin
                sctl.deg_addr = a_reg;
                if (deg_full)
                begin
                    status_next = ST_DEGREE;
                end
            end
            S_CHK_B:
            begin
                sctl.deg_addr = b_reg;
                if (deg_full)
                begin
                    status_next = ST_DEGREE;
                end
                else if (a_reg == b_reg)
                begin
                    status_next = ST_ROOT;
                end
            end
            S_WALK_A:
            begin
                if (at_root)
                begin
                    ra_next  = cur_reg;
                    cur_next = b_reg;
                end
                else
                begin
                    cur_next = srd.link_rdata;
                end
            end
            S_WALK_B:
            begin
                if (!at_root)
                begin
                    cur_next = srd.link_rdata;
                end
            end
            S_DECIDE:
            begin
                sctl.deg_addr = a_reg;
                if (!edge_taken)
                begin
                    status_next = ST_ROOT;
                end
                else if (path_phase)
                begin
                    sctl.link_we  = 1'b1;
                    sctl.deg_inc  = 1'b1;
                    slot_next     = count_reg[VTX_W-1:0];
                    count_next    = count_reg + CNT_W'(1);
                    status_next   = ST_PATH;
                end
                else
                begin
                    sctl.deg_inc  = 1'b1;
                    closed_next   = 1'b1;
                    slot_next     = last_slot[VTX_W-1:0];
                    status_next   = ST_CLOSE;
                end
            end
            S_INC_B:
            begin
                sctl.deg_addr = b_reg;
                sctl.deg_inc  = 1'b1;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = status_reg;
                    out_slot_next     = slot_reg;
                    out_complete_next = closed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg            <= a_next;
        b_reg            <= b_next;
        cur_reg          <= cur_next;
        ra_reg           <= ra_next;
        status_reg       <= status_next;
        slot_reg         <= slot_next;
        out_status_reg   <= out_status_next;
        out_slot_reg     <= out_slot_next;
        out_complete_reg <= out_complete_next;
    end

endmodule

`default_nettype wire

// ===== src/greedy_edge_tour_builder.sv =====
// Greedy edge tour builder. Edges arrive on in_ch, already sorted by ascending
// length, and each item produces exactly one result item on out_ch.
// An item with operation clear resets the forest, the degrees, the edge count
// and the complete flag; an edge item is checked against the degree limit and
// the union-find roots of its endpoints and is taken as a path edge or as the
// closing edge, or rejected.
// The vertex count register is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, which the block does
// not enforce. Values below 2 or above 16 are used as 2 or 16. in_ch.ready is
// high only while the sequencer is idle. A clear or an early reject goes straight
// to the response state, a degree reject passes one or both degree checks, and
// the root walks of an edge follow one parent link per cycle, through one
// shared compare unit, from each endpoint to its root before the decide state.
// The result sits in an output register, and the next item is accepted while it
// waits. If out_ch stalls with a result still pending, the next item finishes
// its work and then waits until the output register frees up.
// Reset leaves the vertex count at 16, every vertex its own root with degree 0,
// and no result pending.
`timescale 1ns / 1ps
`default_nettype none

module greedy_edge_tour_builder (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [gtb_pkg::CNT_W-1:0] cfg_wr_data,
    gtb_in_if.sink                         in_ch,
    gtb_out_if.source                      out_ch
);
    import gtb_pkg::*;

    logic [CNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] live_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        priority if (vertex_count_reg < COUNT_MIN)
        begin
            live_count = COUNT_MIN;
        end
        else if (vertex_count_reg > COUNT_MAX)
        begin
            live_count = COUNT_MAX;
        end
        else
        begin
            live_count = vertex_count_reg;
        end
    end

    gtb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .live_count (live_count),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== tb/greedy_edge_tour_builder_tb.sv =====
`timescale 1ns / 1ps

module greedy_edge_tour_builder_tb;

    import gtb_pkg::*;

    typedef struct packed {
        gtb_status_t      status;
        logic [VTX_W-1:0] slot;
        logic             done;
    } tour_result_t;

    typedef struct packed {
        logic             wr_cnt;
        logic [CNT_W-1:0] cnt;
        logic             op;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic             typed;
        tour_result_t     want;
    } edge_row_t;

    localparam int DIR_ROWS = 22;
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_ITEMS = 520;

    // Rows that carry a typed result are checked against it; the rest use the predictor.
    localparam edge_row_t EDGE_PLAN [DIR_ROWS] = '{
        '{1'b0, 5'd0,  OP_EDGE,  4'd15, 4'd15, 1'b1, '{ST_ROOT,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd0,  4'd15, 1'b1, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd15, 4'd0,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_CLEAR, 4'd15, 4'd15, 1'b1, '{ST_CLEARED, 4'd0, 1'b0}},
        '{1'b1, 5'd3,  OP_EDGE,  4'd0,  4'd3,  1'b1, '{ST_DEGREE,  4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd0,  4'd1,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd2,  4'd1,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd1,  4'd0,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd0,  4'd0,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd2,  4'd0,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd15, 4'd15, 1'b1, '{ST_DONE,    4'd0, 1'b1}},
        '{1'b0, 5'd0,  OP_CLEAR, 4'd0,  4'd0,  1'b1, '{ST_CLEARED, 4'd0, 1'b0}},
        '{1'b1, 5'd2,  OP_EDGE,  4'd1,  4'd0,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd0,  4'd1,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_CLEAR, 4'd7,  4'd9,  1'b1, '{ST_CLEARED, 4'd0, 1'b0}},
        '{1'b1, 5'd0,  OP_EDGE,  4'd0,  4'd2,  1'b1, '{ST_DEGREE,  4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd0,  4'd1,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b1, 5'd31, OP_EDGE,  4'd1,  4'd15, 1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_EDGE,  4'd15, 4'd0,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b1, 5'd1,  OP_EDGE,  4'd0,  4'd1,  1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b1, 5'd17, OP_EDGE,  4'd14, 4'd13, 1'b0, '{ST_PATH,    4'd0, 1'b0}},
        '{1'b0, 5'd0,  OP_CLEAR, 4'd15, 4'd0,  1'b1, '{ST_CLEARED, 4'd0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    gtb_in_if in_ch ();
    gtb_out_if out_ch ();

    greedy_edge_tour_builder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    logic [VTX_W-1:0] forest [MAX_VERTICES];
    logic [DEG_W-1:0] degree [MAX_VERTICES];
    logic [CNT_W-1:0] edge_count;
    logic             closed;
    logic [CNT_W-1:0] count_reg;

    tour_result_t pending_results [$];
    tour_result_t oldest_result;
    int mismatches = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    always #5 clk = ~clk;

    function automatic logic [CNT_W-1:0] vertices_in_use();
        if (count_reg < COUNT_MIN)
            return COUNT_MIN;
        if (count_reg > COUNT_MAX)
            return COUNT_MAX;
        return count_reg;
    endfunction

    function automatic logic [VTX_W-1:0] root_of(input logic [VTX_W-1:0] v);
        logic [VTX_W-1:0] cur;
        cur = v;
        for (int i = 0; i < MAX_VERTICES; i++)
            cur = forest[cur];
        return cur;
    endfunction

    task automatic clear_forest();
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            forest[v] = VTX_W'(v);
            degree[v] = '0;
        end
        edge_count = '0;
        closed = 1'b0;
    endtask

    task automatic predict_step(input logic op, input logic [VTX_W-1:0] a,
                                input logic [VTX_W-1:0] b, output tour_result_t r);
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] last_slot;
        logic [VTX_W-1:0] ra;
        logic [VTX_W-1:0] rb;
        n = vertices_in_use();
        last_slot = n - 5'd1;
        r.status = ST_DEGREE;
        r.slot = '0;
        if (op == OP_CLEAR)
        begin
            clear_forest();
            r.status = ST_CLEARED;
        end
        else if (closed)
            r.status = ST_DONE;
        else if (a >= n || b >= n || degree[a] >= DEG_FULL || degree[b] >= DEG_FULL)
            r.status = ST_DEGREE;
        else if (a == b)
            r.status = ST_ROOT;
        else
        begin
            ra = root_of(a);
            rb = root_of(b);
            if (edge_count < last_slot)
            begin
                if (ra == rb)
                    r.status = ST_ROOT;
                else
                begin
                    forest[rb] = ra;
                    degree[a] = degree[a] + 1'b1;
                    degree[b] = degree[b] + 1'b1;
                    r.slot = edge_count[VTX_W-1:0];
                    edge_count = edge_count + 1'b1;
                    r.status = ST_PATH;
                end
            end
            else if (ra != rb)
                r.status = ST_ROOT;
            else
            begin
                degree[a] = degree[a] + 1'b1;
                degree[b] = degree[b] + 1'b1;
                closed = 1'b1;
                r.slot = last_slot[VTX_W-1:0];
                r.status = ST_CLOSE;
            end
        end
        r.done = closed;
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        wait_for_results();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        count_reg = value;
    endtask

    task automatic offer_item(input logic op, input logic [VTX_W-1:0] a,
                              input logic [VTX_W-1:0] b, input logic typed,
                              input tour_result_t want);
        tour_result_t predicted;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.from_vertex <= a;
        in_ch.to_vertex <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_step(op, a, b, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result with no item waiting, status %0d",
                                              out_ch.status));
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (out_ch.status !== oldest_result.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_ch.status, oldest_result.status));
                    if (out_ch.tour_slot !== oldest_result.slot)
                        report_mismatch($sformatf("tour_slot %0d, expected %0d",
                                                  out_ch.tour_slot, oldest_result.slot));
                    if (out_ch.tour_complete !== oldest_result.done)
                        report_mismatch($sformatf("tour_complete %0d, expected %0d",
                                                  out_ch.tour_complete, oldest_result.done));
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int unsigned tour_items;
        int n;
        int j;
        int stop_at;
        logic [VTX_W-1:0] order [MAX_VERTICES];
        logic [VTX_W-1:0] swap_tmp;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.operation <= OP_CLEAR;
        in_ch.from_vertex <= '0;
        in_ch.to_vertex <= '0;
        count_reg = COUNT_RST;
        clear_forest();
        tour_items = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            if (EDGE_PLAN[k].wr_cnt)
                write_vertex_count(EDGE_PLAN[k].cnt);
            offer_item(EDGE_PLAN[k].op, EDGE_PLAN[k].a, EDGE_PLAN[k].b,
                       EDGE_PLAN[k].typed, EDGE_PLAN[k].want);
        end

        // Mostly well-formed tours on a shuffled vertex order, with noise and cut-off tours.
        while (tour_items < RANDOM_ITEMS)
        begin
            calm = (tour_items >= CALM_ITEMS);
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    write_vertex_count(CNT_W'($urandom_range(0, 31)));
                else if ($urandom_range(0, 9) == 0)
                    write_vertex_count(COUNT_MAX);
                else
                    write_vertex_count(CNT_W'($urandom_range(2, 6)));
            end
            n = int'(vertices_in_use());
            for (int i = 0; i < n; i++)
                order[i] = VTX_W'(i);
            for (int i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                swap_tmp = order[i];
                order[i] = order[j];
                order[j] = swap_tmp;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                offer_item(OP_CLEAR, VTX_W'($urandom_range(0, 15)),
                           VTX_W'($urandom_range(0, 15)), 1'b0, '0);
                tour_items++;
            end
            stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : n;
            for (int i = 0; i < stop_at; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    offer_item(($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_EDGE,
                               VTX_W'($urandom_range(0, 15)),
                               VTX_W'($urandom_range(0, 15)), 1'b0, '0);
                    tour_items++;
                end
                if ($urandom_range(0, 1) == 1)
                    offer_item(OP_EDGE, order[i], order[(i + 1) % n], 1'b0, '0);
                else
                    offer_item(OP_EDGE, order[(i + 1) % n], order[i], 1'b0, '0);
                tour_items++;
            end
            repeat ($urandom_range(0, 2))
            begin
                offer_item(OP_EDGE, VTX_W'($urandom_range(0, 15)),
                           VTX_W'($urandom_range(0, 15)), 1'b0, '0);
                tour_items++;
            end
        end

        wait_for_results();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== greedy_edge_tour_builder.f =====
src/gtb_pkg.sv
src/gtb_in_if.sv
src/gtb_out_if.sv
src/gtb_store.sv
src/gtb_ctrl.sv
src/greedy_edge_tour_builder.sv
tb/greedy_edge_tour_builder_tb.sv
